/* rtl/dfpac_pkg.sv */
// shared types, constants and operation codes for the double add/compare unit
package dfpac_pkg;

  localparam int ExpW  = 11;
  localparam int FracW = 52;
  localparam int SigW  = 53;
  localparam int SumW  = 106;
  localparam int AlnW  = 105;

  localparam logic [ExpW-1:0] EXP_ONES = 11'h7FF;

  // operation codes
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_EQ  = 3'd2;
  localparam logic [2:0] ACT_LT  = 3'd3;
  localparam logic [2:0] ACT_LE  = 3'd4;
  localparam logic [2:0] ACT_MAX = 3'd5;
  localparam logic [2:0] ACT_MIN = 3'd6;

  // leading-one code for a carry out of the top bit
  localparam logic [6:0] LS_CARRY = 7'h7F;

  localparam int InDataW  = 136;
  localparam int OutDataW = 72;

  // per-request info carried through the decode, add and normalize stages
  typedef struct packed {
    logic [2:0]      action;
    logic [63:0]     a;
    logic [63:0]     b;
    logic            sub_like;
    logic            sa;
    logic            sbe;
    logic            nan_a;
    logic            nan_b;
    logic            both_inf;
    logic            all_zero;
    logic            gt;
    logic            eq;
    logic            lt;
    logic [ExpW-1:0] big_exp;
    logic            big_sign;
    logic            eff_sub;
  } meta_t;

  typedef struct packed {
    meta_t           m;
    logic [11:0]     shift;
    logic [SigW-1:0] big;
    logic [SigW-1:0] small_sig;
  } dec_t;

  typedef struct packed {
    meta_t           m;
    logic [SumW-1:0] sum;
  } add_t;

  typedef struct packed {
    meta_t           m;
    logic [AlnW-1:0] align;
    logic [11:0]     eps;
  } nrm_t;

  typedef struct packed {
    logic [63:0] value;
    logic        invalid;
    logic        overflow;
  } res_t;

endpackage

/* rtl/dfpac_decode.sv */
// operand decode, exponent difference, magnitude compare and operand swap
module dfpac_decode import dfpac_pkg::*; (
  input  logic [2:0]  action,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output dec_t        dec
);

  logic            sa, sb, sbe, sub_like, take_a;
  logic [ExpW-1:0] ea, eb;
  logic [SigW-1:0] ma, mb;
  logic [11:0]     ediff;

  // field split
  always_comb begin
    sub_like = (action == ACT_SUB) || (action == ACT_LT) || (action == ACT_LE);
    sa  = operand_a[63];
    sb  = operand_b[63];
    sbe = sb ^ sub_like;
    ea  = operand_a[62:52];
    eb  = operand_b[62:52];
    ma  = {(ea != '0), operand_a[51:0]};
    mb  = {(eb != '0), operand_b[51:0]};
  end

  // exponent difference, subnormals count as exponent one
  always_comb begin
    if (ea != '0 && eb == '0) begin
      ediff = {1'b0, ea} - 12'd1;
    end else if (ea == '0 && eb != '0) begin
      ediff = 12'd1 - {1'b0, eb};
    end else begin
      ediff = {1'b0, ea} - {1'b0, eb};
    end
  end

  // pick the larger operand and the compare outcome
  always_comb begin
    dec = '0;
    if (ediff == '0) begin
      dec.shift = '0;
      if (ma == mb) begin
        take_a   = 1'b1;
        dec.m.gt = !sa && (sa ^ sb);
        dec.m.eq = !(sa ^ sb);
        dec.m.lt = sa && (sa ^ sb);
      end else begin
        take_a   = ma > mb;
        dec.m.gt = take_a ? !sa : sb;
        dec.m.eq = 1'b0;
        dec.m.lt = take_a ? sa : !sb;
      end
    end else begin
      take_a    = !ediff[11];
      dec.shift = take_a ? ediff : (12'd0 - ediff);
      dec.m.gt  = take_a ? !sa : sb;
      dec.m.eq  = 1'b0;
      dec.m.lt  = take_a ? sa : !sb;
    end
    dec.m.action   = action;
    dec.m.a        = operand_a;
    dec.m.b        = operand_b;
    dec.m.sub_like = sub_like;
    dec.m.sa       = sa;
    dec.m.sbe      = sbe;
    dec.m.nan_a    = (ea == EXP_ONES);
    dec.m.nan_b    = (eb == EXP_ONES);
    dec.m.both_inf = (ea == EXP_ONES) && (operand_a[51:0] == '0) &&
                     (eb == EXP_ONES) && (operand_b[51:0] == '0);
    dec.m.all_zero = (operand_a[62:0] == '0) && (operand_b[62:0] == '0);
    dec.m.big_sign = take_a ? sa : sbe;
    dec.m.big_exp  = take_a ? ea : eb;
    dec.m.eff_sub  = sa ^ sbe;
    dec.big        = take_a ? ma : mb;
    dec.small_sig  = take_a ? mb : ma;
  end

endmodule

/* rtl/dfpac_addsub.sv */
// significand alignment and 106-bit add or subtract
module dfpac_addsub import dfpac_pkg::*; (
  input  dec_t dec,
  output add_t add
);

  logic [AlnW-1:0] bs, ss;

  // align the smaller significand under the larger one
  always_comb begin
    bs = {dec.big, {FracW{1'b0}}};
    if (dec.shift < 12'd105) begin
      ss = {dec.small_sig, {FracW{1'b0}}} >> dec.shift[6:0];
    end else begin
      ss = '0;
    end
  end

  // magnitude add or subtract
  always_comb begin
    add.m = dec.m;
    if (dec.m.eff_sub) begin
      add.sum = {1'b0, bs} - {1'b0, ss};
    end else begin
      add.sum = {1'b0, bs} + {1'b0, ss};
    end
  end

endmodule

/* rtl/dfpac_norm.sv */
// leading-one search, left normalize and exponent adjust
module dfpac_norm import dfpac_pkg::*; (
  input  add_t add,
  output nrm_t nrm
);

  logic [6:0]      ls;
  logic [SumW-1:0] shl;
  logic [11:0]     eps;
  logic [11:0]     bexp;

  // leading-one position relative to bit 104
  always_comb begin
    ls = '0;
    if (add.sum[105]) begin
      ls = LS_CARRY;
    end else if (!add.sum[104]) begin
      for (int k = 104; k >= 1; k--) begin
        if (add.sum[104-k]) begin
          ls = 7'(k);
        end
      end
    end
  end

  // normalized significand
  always_comb begin
    shl = add.sum << ls;
    if (ls == LS_CARRY) begin
      nrm.align = add.sum[105:1];
    end else begin
      nrm.align = shl[AlnW-1:0];
    end
  end

  // post-scale exponent
  always_comb begin
    bexp = {1'b0, add.m.big_exp};
    if (ls == LS_CARRY) begin
      eps = (add.m.big_exp == EXP_ONES) ? bexp : bexp + 12'd1;
    end else if (add.m.big_exp == '0 && ls == '0) begin
      eps = 12'd1;
    end else begin
      eps = bexp - {5'd0, ls};
    end
    if (add.m.eff_sub && add.m.big_exp != '0 && (eps[11] || eps == '0)) begin
      eps = eps - 12'd1;
    end
    nrm.eps = eps;
    nrm.m   = add.m;
  end

endmodule

/* rtl/dfpac_round.sv */
// denormal shift, rounding, special cases and result select
module dfpac_round import dfpac_pkg::*; (
  input  nrm_t nrm,
  output res_t res
);

  logic [11:0]      neg;
  logic [AlnW-1:0]  post;
  logic [SigW-1:0]  top;
  logic [FracW-1:0] guard, frac;
  logic             ones, rnd, sum_zero, ovf, sign, nan_any;
  logic [ExpW-1:0]  expf;
  logic [63:0]      packed_val;

  // right shift for an underflowed exponent, then round
  always_comb begin
    neg = 12'd0 - nrm.eps;
    if (nrm.eps[11] && neg >= 12'd1 && neg <= 12'd104) begin
      post = nrm.align >> neg[6:0];
    end else begin
      post = nrm.align;
    end
    top      = post[AlnW-1:FracW];
    guard    = post[FracW-1:0];
    ones     = &top;
    rnd      = guard[51] && !(guard == {1'b1, 51'd0} && !top[0]);
    sum_zero = (post == '0);
    ovf      = (nrm.eps == {1'b0, EXP_ONES});
    nan_any  = nrm.m.nan_a || nrm.m.nan_b;
  end

  // sign, exponent and fraction of the sum
  always_comb begin
    if (nrm.m.both_inf && nrm.m.sub_like) begin
      sign = nrm.m.sa ^ nrm.m.sbe;
    end else if (nrm.m.nan_a) begin
      sign = nrm.m.sa || (nrm.m.nan_b && nrm.m.sbe);
    end else if (nrm.m.nan_b) begin
      sign = nrm.m.sbe ^ (nrm.m.sub_like && (nrm.m.b[51:0] != '0));
    end else if (nrm.m.all_zero) begin
      sign = nrm.m.sa && nrm.m.sbe;
    end else if (sum_zero) begin
      sign = 1'b0;
    end else begin
      sign = nrm.m.big_sign;
    end

    if (nan_any) begin
      expf = EXP_ONES;
    end else if (nrm.eps[11] || sum_zero) begin
      expf = '0;
    end else begin
      expf = nrm.eps[10:0] + {10'd0, (ones && rnd && !ovf)};
    end

    if (nrm.m.both_inf) begin
      frac = {nrm.m.sub_like, 51'd0};
    end else if (nrm.m.nan_a && !(nrm.m.nan_b && nrm.m.sbe)) begin
      frac = {1'b1, nrm.m.a[50:0]};
    end else if (nrm.m.nan_b) begin
      frac = {1'b1, nrm.m.b[50:0]};
    end else if (ovf) begin
      frac = '0;
    end else begin
      frac = top[FracW-1:0] + {51'd0, rnd};
    end
    packed_val = {sign, expf, frac};
  end

  // result by operation
  always_comb begin
    case (nrm.m.action)
      ACT_EQ:  res.value = {63'd0, nrm.m.eq};
      ACT_LT:  res.value = {63'd0, nrm.m.lt};
      ACT_LE:  res.value = {63'd0, (nrm.m.lt || nrm.m.eq)};
      ACT_MAX: res.value = (!nan_any && nrm.m.gt) ? nrm.m.a : nrm.m.b;
      ACT_MIN: res.value = (!nan_any && nrm.m.lt) ? nrm.m.a : nrm.m.b;
      default: res.value = packed_val;
    endcase
    res.invalid  = nan_any;
    res.overflow = ovf;
  end

endmodule

/* rtl/double_fp_add_compare_unit.sv */
// double add/subtract/compare unit, four register stages
// throughput: one request per cycle while the output is not stalled; decode, align-add, normalize and round stages
// each stage moves on when the next is empty or moving, so stalls lose nothing
// reset: synchronous active-low rst_n clears all stage valid bits
module double_fp_add_compare_unit import dfpac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // action[2:0], operand_a[66:3], operand_b[130:67]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata   // result_value[63:0], invalid_flag[64], overflow_flag[65]
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  dec_t s1_nxt, s1_r;
  add_t s2_nxt, s2_r;
  nrm_t s3_nxt, s3_r;
  res_t s4_nxt, s4_r;
  logic [2:0] act4_r;

  // stage logic
  dfpac_decode u_decode (
    .action    (in_tdata[2:0]),
    .operand_a (in_tdata[66:3]),
    .operand_b (in_tdata[130:67]),
    .dec       (s1_nxt)
  );
  dfpac_addsub u_addsub (.dec(s1_r), .add(s2_nxt));
  dfpac_norm   u_norm   (.add(s2_r), .nrm(s3_nxt));
  dfpac_round  u_round  (.nrm(s3_r), .res(s4_nxt));

  // per-stage advance
  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) s1_r <= s1_nxt;
    if (rdy2 && v1_r) s2_r <= s2_nxt;
    if (rdy3 && v2_r) s3_r <= s3_nxt;
    if (rdy4 && v3_r) begin
      s4_r   <= s4_nxt;
      act4_r <= s3_r.m.action;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {6'd0, s4_r.overflow, s4_r.invalid, s4_r.value};

  // stages empty right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // compares give only 0 or 1
  a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (act4_r == ACT_EQ || act4_r == ACT_LT || act4_r == ACT_LE))
      |-> (s4_r.value[63:1] == '0))
    else $error("compare result wider than one bit");

  // an invalid sum carries an all-ones exponent
  a_nan_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && s4_r.invalid && (act4_r == ACT_ADD || act4_r == ACT_SUB))
      |-> (s4_r.value[62:52] == EXP_ONES))
    else $error("invalid sum without all-ones exponent");

endmodule

/* bench/tb_double_fp_add_compare_unit.sv */
// testbench for the double add/compare unit: directed and random requests checked in order
module tb_double_fp_add_compare_unit;
  import dfpac_pkg::*;

  localparam logic [63:0] ONE_D   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] PINF_D  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_D  = 64'h7FF8_0000_0000_1234;
  localparam logic [63:0] MAXF_D  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HALFULP = 64'h3CA0_0000_0000_0000;
  localparam logic [2:0]  ACT_SPARE = 3'd7;

  // expected outcome of one request
  typedef struct {
    logic [63:0] value;
    logic        invalid;
    logic        overflow;
  } outcome_t;

  // keeps the expected outcomes of accepted requests and checks results in order
  class fp_scoreboard;
    outcome_t pending_q[$];
    int mismatches;
    int checked;

    // compute the outcome of one request
    function outcome_t compute(logic [2:0] act, logic [63:0] a, logic [63:0] b);
      outcome_t r;
      logic sub_like, sa, sb, sbe, take_a, gt, eq, lt, eff_sub, big_sign;
      logic nan_a, nan_b, both_inf, all_zero, sum_zero, ovf, ones, rnd, sign;
      logic [10:0] ea, eb, big_exp, expf;
      logic [51:0] fa, fb, guard, frac;
      logic [52:0] ma, mb, big_sig, small_sig, top;
      logic [11:0] ediff, shift, eps, neg;
      logic [105:0] bs, ss, sum, shl;
      logic [104:0] align, post;
      logic [6:0] ls;
      sub_like = (act == ACT_SUB) || (act == ACT_LT) || (act == ACT_LE);
      sa = a[63]; sb = b[63]; sbe = sb ^ sub_like;
      ea = a[62:52]; eb = b[62:52]; fa = a[51:0]; fb = b[51:0];
      ma = {ea != 0, fa}; mb = {eb != 0, fb};
      if (ea != 0 && eb == 0) ediff = {1'b0, ea} - 12'd1;
      else if (ea == 0 && eb != 0) ediff = 12'd1 - {1'b0, eb};
      else ediff = {1'b0, ea} - {1'b0, eb};
      // pick the larger operand and the compare answers
      if (ediff == 0) begin
        shift = 0;
        if (ma == mb) begin
          take_a = 1; gt = !sa && (sa ^ sb); eq = !(sa ^ sb); lt = sa && (sa ^ sb);
        end else begin
          take_a = ma > mb; gt = take_a ? !sa : sb; eq = 0; lt = take_a ? sa : !sb;
        end
      end else begin
        take_a = !ediff[11];
        shift = take_a ? ediff : 12'd0 - ediff;
        gt = take_a ? !sa : sb; eq = 0; lt = take_a ? sa : !sb;
      end
      big_sign = take_a ? sa : sbe;
      big_exp = take_a ? ea : eb;
      big_sig = take_a ? ma : mb;
      small_sig = take_a ? mb : ma;
      // align and add in 106 bits
      bs = {53'd0, big_sig} << 52;
      ss = (shift < 105) ? (({53'd0, small_sig} << 52) >> shift) : 106'd0;
      eff_sub = sa ^ sbe;
      sum = eff_sub ? bs - ss : bs + ss;
      // leading one relative to bit 104, nearest one first
      ls = 0;
      if (sum[105]) ls = LS_CARRY;
      else if (!sum[104]) begin
        for (int k = 1; k <= 104; k++)
          if (ls == 0 && sum[104-k]) ls = 7'(k);
      end
      shl = (ls == LS_CARRY) ? sum >> 1 : sum << ls;
      align = shl[104:0];
      if (ls == LS_CARRY) eps = (big_exp == EXP_ONES) ? {1'b0, big_exp} : {1'b0, big_exp} + 12'd1;
      else if (big_exp == 0 && ls == 0) eps = 12'd1;
      else eps = {1'b0, big_exp} - {5'd0, ls};
      if (eff_sub && big_exp != 0 && (eps[11] || eps == 0)) eps = eps - 12'd1;
      neg = 12'd0 - eps;
      post = align;
      if (eps[11] && neg >= 1 && neg <= 104) post = align >> neg;
      // round to nearest, tie dropped only on an even kept bit
      top = post[104:52];
      guard = post[51:0];
      ones = &top;
      rnd = guard[51] && !(guard == 52'h8_0000_0000_0000 && !top[0]);
      nan_a = ea == EXP_ONES;
      nan_b = eb == EXP_ONES;
      both_inf = nan_a && fa == 0 && nan_b && fb == 0;
      all_zero = a[62:0] == 0 && b[62:0] == 0;
      sum_zero = post == 0;
      ovf = eps == {1'b0, EXP_ONES};
      if (both_inf && sub_like) sign = sa ^ sbe;
      else if (nan_a) sign = sa || (nan_b && sbe);
      else if (nan_b) sign = sbe ^ (sub_like && fb != 0);
      else if (all_zero) sign = sa && sbe;
      else if (sum_zero) sign = 0;
      else sign = big_sign;
      if (nan_a || nan_b) expf = EXP_ONES;
      else if (eps[11] || sum_zero) expf = 0;
      else expf = eps[10:0] + ((ones && rnd && !ovf) ? 11'd1 : 11'd0);
      if (both_inf) frac = {sub_like, 51'd0};
      else if (nan_a && !(nan_b && sbe)) frac = {1'b1, a[50:0]};
      else if (nan_b) frac = {1'b1, b[50:0]};
      else if (ovf) frac = 0;
      else frac = top[51:0] + {51'd0, rnd};
      case (act)
        ACT_EQ:  r.value = {63'd0, eq};
        ACT_LT:  r.value = {63'd0, lt};
        ACT_LE:  r.value = {63'd0, lt || eq};
        ACT_MAX: r.value = (!(nan_a || nan_b) && gt) ? a : b;
        ACT_MIN: r.value = (!(nan_a || nan_b) && lt) ? a : b;
        default: r.value = {sign, expf, frac};
      endcase
      r.invalid = nan_a || nan_b;
      r.overflow = ovf;
      return r;
    endfunction

    function void note_request(logic [InDataW-1:0] d);
      pending_q.push_back(compute(d[2:0], d[66:3], d[130:67]));
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      outcome_t e;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending_q.pop_front();
      if (d[63:0] !== e.value || d[64] !== e.invalid || d[65] !== e.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp value %h inv %b ovf %b, got value %h inv %b ovf %b",
                   checked, e.value, e.invalid, e.overflow, d[63:0], d[64], d[65]);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OutDataW-1:0] out_tdata;

  fp_scoreboard sb = new();
  bit gaps_on = 1;
  bit hold_rx = 0;
  int sent = 0;

  double_fp_add_compare_unit dut (.*);

  always #5 clk = ~clk;

  // watch both channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // drive one request and wait for it to be taken
  task automatic send_request(logic [2:0] act, logic [63:0] a, logic [63:0] b);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {5'd0, b, a, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // operand drawn from a mix of special and ordinary values
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v[62:0] = 0;
      1: v[62:0] = {11'h7FF, 52'd0};
      2: v[62:52] = 11'h7FF;
      3: v[62:52] = 0;
      4: v[62:0] = MAXF_D[62:0];
      5: v[62:52] = 11'(11'h3FF + $urandom_range(0, 4) - 2);
      default: ;
    endcase
    return v;
  endfunction

  // second operand often tied to the first so exponents line up
  function automatic logic [63:0] pick_partner(logic [63:0] a);
    logic [63:0] v;
    v = a;
    case ($urandom_range(0, 5))
      0: ;
      1: v[63] = ~v[63];
      2: v[0] = ~v[0];
      3: begin
        v[51:0] = 52'({$urandom, $urandom});
        v[62:52] = 11'(a[62:52] + $urandom_range(0, 6) - 3);
      end
      4: v[62:52] = 11'(a[62:52] + $urandom_range(0, 120) - 60);
      default: v = pick_operand();
    endcase
    return v;
  endfunction

  // receiver: random stalls, one long hold on request
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        hold_rx = 0;
        out_tready <= 0;
        repeat (300) @(posedge clk);
      end
      stall = gaps_on ? $urandom_range(0, 14) : 0;
      repeat (stall) begin
        out_tready <= 0;
        @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [63:0] a;
    int errors;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed corners
    send_request(ACT_ADD, ONE_D, ONE_D);
    send_request(ACT_SUB, ONE_D, ONE_D);
    send_request(ACT_ADD, 64'h0, 64'h8000_0000_0000_0000);
    send_request(ACT_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_request(ACT_ADD, PINF_D, PINF_D);
    send_request(ACT_SUB, PINF_D, PINF_D);
    send_request(ACT_ADD, QNAN_D, ONE_D);
    send_request(ACT_SUB, ONE_D, 64'hFFF4_0000_0000_0001);
    send_request(ACT_ADD, QNAN_D, 64'hFFF0_0000_0000_0055);
    send_request(ACT_ADD, 64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF);
    send_request(ACT_SUB, 64'h0010_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_request(ACT_ADD, MAXF_D, MAXF_D);
    send_request(ACT_ADD, ONE_D, HALFULP);
    send_request(ACT_ADD, 64'h3FF0_0000_0000_0001, HALFULP);
    send_request(ACT_ADD, 64'h3FFF_FFFF_FFFF_FFFF, HALFULP);
    send_request(ACT_SUB, MAXF_D, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_EQ, 64'h0, 64'h8000_0000_0000_0000);
    send_request(ACT_EQ, ONE_D, ONE_D);
    send_request(ACT_LT, 64'hBFF0_0000_0000_0000, ONE_D);
    send_request(ACT_LE, ONE_D, ONE_D);
    send_request(ACT_MAX, ONE_D, QNAN_D);
    send_request(ACT_MAX, 64'h4000_0000_0000_0000, ONE_D);
    send_request(ACT_MIN, 64'h4000_0000_0000_0000, ONE_D);
    send_request(ACT_MIN, PINF_D, ONE_D);
    send_request(ACT_SPARE, ONE_D, HALFULP);
    // random requests, with a gap-free stretch and one long output hold
    for (int i = 0; i < 650; i++) begin
      if (i == 250) gaps_on = 0;
      if (i == 380) gaps_on = 1;
      if (i == 420) hold_rx = 1;
      a = pick_operand();
      send_request(3'($urandom_range(0, 7)), a, pick_partner(a));
    end
    in_tvalid <= 0;
    wait (sb.pending_q.size() == 0);
    repeat (20) @(posedge clk);
    errors = sb.mismatches + sb.pending_q.size();
    $display("%0d requests sent, %0d results checked, %0d mismatches", sent, sb.checked,
             sb.mismatches);
    $display("covered add/sub/compare/max/min with zeros, subnormals, infinities and nans");
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
